>>> hdl/ebl_pkg.sv
`default_nettype none

package ebl_pkg;

    localparam int ECHO_W   = 16;
    localparam int DIST_W   = 15;
    localparam int STATUS_W = 3;
    localparam int SUM_W    = 17;
    localparam int SCNT_W   = 4;
    localparam int VCNT_W   = 3;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_SAMPLES_DEF  = 10;
    localparam int WANTED_VALID_DEF = 5;

    localparam int DIST_MUL_W = 10;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = 10'd557;
    localparam int DIST_SHIFT = 11;
    localparam int DIST_PROD_W = ECHO_W + DIST_MUL_W;

    localparam logic [DIST_W-1:0] DRIFT_LIMIT  = 15'd160;
    localparam logic [DIST_W-1:0] SMOOTH_RESET = 15'd800;
    localparam logic [DIST_W-1:0] DEADZONE_RESET = 15'd352;
    localparam logic [DIST_W-1:0] MAX_DEPTH_RESET = 15'd2400;

    localparam int BLEND_W    = DIST_W + 3;
    localparam int RECIP5_W   = 16;
    localparam logic [RECIP5_W-1:0] RECIP5 = 16'd52429;
    localparam int RECIP5_SHIFT = 18;
    localparam int BLEND_PROD_W = BLEND_W + RECIP5_W;

    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [STATUS_W-1:0] ST_TIMEOUT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEADZONE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DRIFT        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INIT         = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 1'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [VCNT_W-1:0] vcnt;
    } burst_t;

    typedef struct packed {
        logic [DIST_W-1:0] deadzone_limit;
        logic [DIST_W-1:0] max_depth_limit;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/ebl_front.sv
`default_nettype none

module ebl_front #(
    parameter int MAX_SAMPLES  = ebl_pkg::MAX_SAMPLES_DEF,
    parameter int WANTED_VALID = ebl_pkg::WANTED_VALID_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [ebl_pkg::ECHO_W-1:0]  s_echo_time,
    input  wire logic                        q_full,
    output logic                             q_push,
    output ebl_pkg::burst_t                  q_data
);

    localparam logic [ebl_pkg::SCNT_W-1:0] MAX_S  = ebl_pkg::SCNT_W'(MAX_SAMPLES);
    localparam logic [ebl_pkg::VCNT_W-1:0] WANT_V = ebl_pkg::VCNT_W'(WANTED_VALID);

    logic [ebl_pkg::SCNT_W-1:0]      scnt_reg, scnt_next;
    logic [ebl_pkg::VCNT_W-1:0]      vcnt_reg, vcnt_next;
    logic [ebl_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [ebl_pkg::DIST_PROD_W-1:0] dist_prod;
    logic [ebl_pkg::DIST_W-1:0]      dist_val;
    logic [ebl_pkg::SCNT_W-1:0]      scnt_inc;
    logic [ebl_pkg::VCNT_W-1:0]      vcnt_inc;
    logic [ebl_pkg::SUM_W-1:0]       sum_inc;
    logic                            hit;
    logic                            burst_end;
    logic                            accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        hit       = (s_echo_time != '0);
        dist_prod = ebl_pkg::DIST_PROD_W'(s_echo_time)
                    * ebl_pkg::DIST_PROD_W'(ebl_pkg::DIST_MUL);
        dist_val  = dist_prod[ebl_pkg::DIST_SHIFT +: ebl_pkg::DIST_W];
        scnt_inc  = scnt_reg + 1'b1;
        vcnt_inc  = vcnt_reg + ebl_pkg::VCNT_W'(hit);
        sum_inc   = hit ? sum_reg + ebl_pkg::SUM_W'(dist_val) : sum_reg;
        burst_end = (scnt_inc >= MAX_S) || (vcnt_inc >= WANT_V);

        q_push      = accept && burst_end;
        q_data.sum  = sum_inc;
        q_data.vcnt = vcnt_inc;

        scnt_next = scnt_reg;
        vcnt_next = vcnt_reg;
        sum_next  = sum_reg;
        if (accept) begin
            if (burst_end) begin
                scnt_next = '0;
                vcnt_next = '0;
                sum_next  = '0;
            end else begin
                scnt_next = scnt_inc;
                vcnt_next = vcnt_inc;
                sum_next  = sum_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scnt_reg <= '0;
            vcnt_reg <= '0;
            sum_reg  <= '0;
        end else begin
            scnt_reg <= scnt_next;
            vcnt_reg <= vcnt_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ebl_queue.sv
`default_nettype none

module ebl_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire ebl_pkg::burst_t push_data,
    output logic                 full,
    output logic                 q_valid,
    output ebl_pkg::burst_t      q_data,
    input  wire logic            pop
);

    ebl_pkg::burst_t entry_reg [ebl_pkg::QUEUE_DEPTH];

    logic [ebl_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ebl_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ebl_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                       do_push;
    logic                       do_pop;

    assign full    = (cnt_reg == ebl_pkg::QCNT_W'(ebl_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        do_push = push && !full;
        do_pop  = pop && q_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == ebl_pkg::QPTR_W'(ebl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == ebl_pkg::QPTR_W'(ebl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end

        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ebl_back.sv
`default_nettype none

module ebl_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire ebl_pkg::burst_t               q_data,
    output logic                               q_pop,
    input  wire ebl_pkg::cfg_t                 cfg,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ebl_pkg::STATUS_W-1:0]       m_status,
    output logic [ebl_pkg::DIST_W-1:0]         m_mean_distance,
    output logic [ebl_pkg::DIST_W-1:0]         m_filtered_distance
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] S_DIV   = 3'd1;
    localparam logic [STATE_W-1:0] S_CLASS = 3'd2;
    localparam logic [STATE_W-1:0] S_UPD   = 3'd3;
    localparam logic [STATE_W-1:0] S_OUT   = 3'd4;

    logic [STATE_W-1:0]                   state_reg, state_next;
    logic [ebl_pkg::SUM_W-1:0]            quo_reg, quo_next;
    logic [ebl_pkg::VCNT_W-1:0]           rem_reg, rem_next;
    logic [ebl_pkg::VCNT_W-1:0]           divisor_reg, divisor_next;
    logic [ebl_pkg::DIV_CNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic [ebl_pkg::STATUS_W-1:0]         st_reg, st_next;
    logic [ebl_pkg::DIST_W-1:0]           mean_reg, mean_next;
    logic [ebl_pkg::BLEND_PROD_W-1:0]     prod_reg, prod_next;
    logic [ebl_pkg::DIST_W-1:0]           smooth_reg, smooth_next;
    logic [ebl_pkg::STATUS_W-1:0]         last_st_reg, last_st_next;
    logic                                 first_run_reg, first_run_next;
    logic                                 m_valid_reg, m_valid_next;
    logic [ebl_pkg::STATUS_W-1:0]         m_status_reg, m_status_next;
    logic [ebl_pkg::DIST_W-1:0]           m_mean_reg, m_mean_next;
    logic [ebl_pkg::DIST_W-1:0]           m_filt_reg, m_filt_next;

    logic [ebl_pkg::VCNT_W:0]             rem_shift;
    logic                                 quo_bit;
    logic [ebl_pkg::DIST_W-1:0]           mean_c;
    logic [ebl_pkg::DIST_W-1:0]           diff;
    logic [ebl_pkg::BLEND_W-1:0]          blend;
    logic                                 out_free;

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_mean_distance     = m_mean_reg;
    assign m_filtered_distance = m_filt_reg;

    always_comb begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        div_cnt_next   = div_cnt_reg;
        st_next        = st_reg;
        mean_next      = mean_reg;
        prod_next      = prod_reg;
        smooth_next    = smooth_reg;
        last_st_next   = last_st_reg;
        first_run_next = first_run_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_mean_next    = m_mean_reg;
        m_filt_next    = m_filt_reg;
        q_pop          = 1'b0;

        rem_shift = {rem_reg, quo_reg[ebl_pkg::SUM_W-1]};
        quo_bit   = (rem_shift >= {1'b0, divisor_reg});
        mean_c    = (divisor_reg == '0) ? '0 : quo_reg[ebl_pkg::DIST_W-1:0];
        diff      = (mean_c > smooth_reg) ? mean_c - smooth_reg : smooth_reg - mean_c;
        blend     = ebl_pkg::BLEND_W'({smooth_reg, 2'b00}) + ebl_pkg::BLEND_W'(mean_c)
                    + ebl_pkg::BLEND_W'(2);
        out_free  = !m_valid_reg || m_ready;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    quo_next     = q_data.sum;
                    divisor_next = q_data.vcnt;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                rem_next = quo_bit ? ebl_pkg::VCNT_W'(rem_shift - {1'b0, divisor_reg})
                                   : rem_shift[ebl_pkg::VCNT_W-1:0];
                quo_next = {quo_reg[ebl_pkg::SUM_W-2:0], quo_bit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == ebl_pkg::DIV_CNT_W'(ebl_pkg::SUM_W - 1)) begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                mean_next = mean_c;
                prod_next = ebl_pkg::BLEND_PROD_W'(blend)
                            * ebl_pkg::BLEND_PROD_W'(ebl_pkg::RECIP5);
                if (divisor_reg == '0) begin
                    st_next = ebl_pkg::ST_TIMEOUT;
                end else if (mean_c <= cfg.deadzone_limit) begin
                    st_next = ebl_pkg::ST_DEADZONE;
                end else if (mean_c > cfg.max_depth_limit) begin
                    st_next = ebl_pkg::ST_OUT_OF_RANGE;
                end else if ((diff > ebl_pkg::DRIFT_LIMIT) && !first_run_reg) begin
                    st_next = ebl_pkg::ST_DRIFT;
                end else if (mean_c < cfg.max_depth_limit) begin
                    st_next = ebl_pkg::ST_OK;
                end else begin
                    st_next = ebl_pkg::ST_INIT;
                end
                state_next = S_UPD;
            end
            S_UPD: begin
                if (st_reg == ebl_pkg::ST_OK) begin
                    if (last_st_reg == ebl_pkg::ST_INIT) begin
                        smooth_next    = mean_reg;
                        first_run_next = 1'b0;
                    end else begin
                        smooth_next = prod_reg[ebl_pkg::RECIP5_SHIFT +: ebl_pkg::DIST_W];
                    end
                end
                last_st_next = st_reg;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_mean_next   = mean_reg;
                    m_filt_next   = smooth_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        div_cnt_reg   <= div_cnt_next;
        st_reg        <= st_next;
        mean_reg      <= mean_next;
        prod_reg      <= prod_next;
        m_status_reg  <= m_status_next;
        m_mean_reg    <= m_mean_next;
        m_filt_reg    <= m_filt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            smooth_reg    <= ebl_pkg::SMOOTH_RESET;
            last_st_reg   <= ebl_pkg::ST_INIT;
            first_run_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            smooth_reg    <= smooth_next;
            last_st_reg   <= last_st_next;
            first_run_reg <= first_run_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/echo_burst_level_classifier.sv
// Echo times enter on the s_ channel at one item per cycle, and the front end converts each
// to a distance and gathers a burst; the input is held off while the two-entry burst queue
// is full. The back end takes one burst at a time, finds the mean with a one-bit-per-cycle
// divider, and may wait on m_ready before it delivers its result. Configuration writes are
// always ready.

`default_nettype none

module echo_burst_level_classifier #(
    parameter int MAX_SAMPLES  = ebl_pkg::MAX_SAMPLES_DEF,
    parameter int WANTED_VALID = ebl_pkg::WANTED_VALID_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ebl_pkg::ECHO_W-1:0]     s_echo_time,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ebl_pkg::STATUS_W-1:0]        m_status,
    output logic [ebl_pkg::DIST_W-1:0]          m_mean_distance,
    output logic [ebl_pkg::DIST_W-1:0]          m_filtered_distance,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ebl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ebl_pkg::DIST_W-1:0]     cfg_data
);

    ebl_pkg::cfg_t   cfg_reg;
    ebl_pkg::burst_t push_data;
    ebl_pkg::burst_t pop_data;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone_limit  <= ebl_pkg::DEADZONE_RESET;
            cfg_reg.max_depth_limit <= ebl_pkg::MAX_DEPTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ebl_pkg::REG_DEADZONE:  cfg_reg.deadzone_limit  <= cfg_data;
                ebl_pkg::REG_MAX_DEPTH: cfg_reg.max_depth_limit <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ebl_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .WANTED_VALID (WANTED_VALID)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_echo_time (s_echo_time),
        .q_full      (q_full),
        .q_push      (push),
        .q_data      (push_data)
    );

    ebl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .pop       (pop)
    );

    ebl_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_valid),
        .q_data              (pop_data),
        .q_pop               (pop),
        .cfg                 (cfg_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_mean_distance     (m_mean_distance),
        .m_filtered_distance (m_filtered_distance)
    );

endmodule

`default_nettype wire
